### design/ebps_pkg.sv
// Shared types and constants for the eased quadratic Bezier path sampler.
// No dependencies; used by the front, queue, back and top-level modules.
package ebps_pkg;

  localparam int unsigned MinSteps = 10;
  localparam int unsigned MaxSteps = 60;
  localparam int unsigned StepW    = 6;
  localparam logic [30:0] QOne     = 31'h4000_0000;

  typedef struct packed {
    logic [14:0]      sx;
    logic [14:0]      sy;
    logic [14:0]      ex;
    logic [14:0]      ey;
    logic [15:0]      cx;
    logic [15:0]      cy;
    logic [StepW-1:0] steps;
  } job_t;

endpackage

### design/ebps_front.sv
// Front end: accepts a path request, finds the control point and step count.
// Uses a shared multiplier, a bit-serial divider and a bit-serial square root.
// Depends on ebps_pkg.
module ebps_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [14:0] start_x_i,
  input  logic signed [14:0] start_y_i,
  input  logic signed [14:0] end_x_i,
  input  logic signed [14:0] end_y_i,
  input  logic signed [14:0] offset_mag_i,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output ebps_pkg::job_t     job_o
);

  typedef enum logic [6:0] {
    F_IDLE  = 7'b0000001,
    F_MUL   = 7'b0000010,
    F_ROOT  = 7'b0000100,
    F_STEPS = 7'b0001000,
    F_DIV   = 7'b0010000,
    F_FIX   = 7'b0100000,
    F_PUSH  = 7'b1000000
  } fstate_e;

  localparam logic [2:0]  OpDxDx   = 3'd0;
  localparam logic [2:0]  OpDyDy   = 3'd1;
  localparam logic [2:0]  OpDyOff  = 3'd2;
  localparam logic [2:0]  OpDxOff  = 3'd3;
  localparam logic [2:0]  OpNxNx   = 3'd4;
  localparam logic [2:0]  OpNyNy   = 3'd5;
  localparam logic [5:0]  RootLast = 6'd29;
  localparam logic [5:0]  DivLast  = 6'd57;
  localparam logic [15:0] ThirdRcp = 16'd43691;

  fstate_e state_q, state_d;
  logic [2:0] op_q, op_d;
  logic       ph_q, ph_d;
  logic [5:0] cnt_q, cnt_d;
  logic       pass_q, pass_d;
  logic       roots_q, roots_d;

  logic [14:0] sx_q, sy_q, ex_q, ey_q, off_q;
  logic [15:0] dx_q, dy_q, cx_q, cy_q;
  logic [31:0] s_q;
  logic [29:0] nx_q, ny_q;
  logic [57:0] sqx_q, sqy_q;
  logic signed [59:0] prod_q;
  logic [31:0] drem_q;
  logic [57:0] dquo_q;
  logic [59:0] rad_q;
  logic [29:0] root_q;
  logic [30:0] irem_q;
  logic [5:0]  steps_q;

  logic signed [29:0] opa, opb;
  logic signed [59:0] prod_d;
  logic [29:0] magx, magy;
  logic [15:0] sumx, sumy, sumx_adj, sumy_adj;
  logic [32:0] irem_sh, itrial, irem_sub;
  logic        ige;
  logic [32:0] drem_sh, drem_sub;
  logic        dge;
  logic [31:0] third;
  logic [14:0] q3, steps_lo;
  logic [5:0]  steps_d;
  logic [17:0] qfix, adj, fix_sum;

  assign magx = nx_q[29] ? (-nx_q) : nx_q;
  assign magy = ny_q[29] ? (-ny_q) : ny_q;

  always_comb begin
    opa = '0;
    opb = '0;
    case (op_q)
      OpDxDx: begin
        opa = {{14{dx_q[15]}}, dx_q};
        opb = {{14{dx_q[15]}}, dx_q};
      end
      OpDyDy: begin
        opa = {{14{dy_q[15]}}, dy_q};
        opb = {{14{dy_q[15]}}, dy_q};
      end
      OpDyOff: begin
        opa = {{14{dy_q[15]}}, dy_q};
        opb = {{15{off_q[14]}}, off_q};
      end
      OpDxOff: begin
        opa = {{14{dx_q[15]}}, dx_q};
        opb = {{15{off_q[14]}}, off_q};
      end
      OpNxNx: begin
        opa = magx;
        opb = magx;
      end
      OpNyNy: begin
        opa = magy;
        opb = magy;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod_d = opa * opb;

  assign sumx     = {start_x_i[14], start_x_i} + {end_x_i[14], end_x_i};
  assign sumy     = {start_y_i[14], start_y_i} + {end_y_i[14], end_y_i};
  assign sumx_adj = sumx + {15'd0, sumx[15]};
  assign sumy_adj = sumy + {15'd0, sumy[15]};

  assign irem_sh  = {irem_q, rad_q[59:58]};
  assign itrial   = {1'b0, root_q, 2'b01};
  assign ige      = irem_sh >= itrial;
  assign irem_sub = ige ? (irem_sh - itrial) : irem_sh;

  assign drem_sh  = {drem_q, dquo_q[57]};
  assign dge      = drem_sh >= {1'b0, s_q};
  assign drem_sub = dge ? (drem_sh - {1'b0, s_q}) : drem_sh;

  assign third    = root_q[15:0] * ThirdRcp;
  assign q3       = third[31:17];
  assign steps_lo = (q3 < 15'(ebps_pkg::MinSteps)) ? 15'(ebps_pkg::MinSteps) : q3;
  assign steps_d  = (steps_lo > 15'(ebps_pkg::MaxSteps)) ? 6'(ebps_pkg::MaxSteps)
                                                          : steps_lo[5:0];

  assign qfix = {1'b0, root_q[16:0]};
  always_comb begin
    if (!pass_q) begin
      adj     = nx_q[29] ? qfix : (-qfix);
      fix_sum = {{2{cx_q[15]}}, cx_q} + adj;
    end else begin
      adj     = ny_q[29] ? (-qfix) : qfix;
      fix_sum = {{2{cy_q[15]}}, cy_q} + adj;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    ph_d    = ph_q;
    cnt_d   = cnt_q;
    pass_d  = pass_q;
    roots_d = roots_q;
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          state_d = F_MUL;
          op_d    = OpDxDx;
          ph_d    = 1'b0;
        end
      end
      F_MUL: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          if (op_q == OpNyNy) begin
            state_d = F_ROOT;
            cnt_d   = '0;
            roots_d = 1'b1;
          end else begin
            op_d = op_q + 3'd1;
          end
        end
      end
      F_ROOT: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == RootLast) begin
          state_d = roots_q ? F_STEPS : F_FIX;
        end
      end
      F_STEPS: begin
        if (s_q > 32'd1) begin
          state_d = F_DIV;
          cnt_d   = '0;
          pass_d  = 1'b0;
        end else begin
          state_d = F_PUSH;
        end
      end
      F_DIV: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == DivLast) begin
          state_d = F_ROOT;
          cnt_d   = '0;
          roots_d = 1'b0;
        end
      end
      F_FIX: begin
        if (pass_q) begin
          state_d = F_PUSH;
        end else begin
          state_d = F_DIV;
          cnt_d   = '0;
          pass_d  = 1'b1;
        end
      end
      F_PUSH: begin
        if (job_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      op_q    <= '0;
      ph_q    <= 1'b0;
      cnt_q   <= '0;
      pass_q  <= 1'b0;
      roots_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      ph_q    <= ph_d;
      cnt_q   <= cnt_d;
      pass_q  <= pass_d;
      roots_q <= roots_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          sx_q  <= start_x_i;
          sy_q  <= start_y_i;
          ex_q  <= end_x_i;
          ey_q  <= end_y_i;
          off_q <= offset_mag_i;
          dx_q  <= {end_x_i[14], end_x_i} - {start_x_i[14], start_x_i};
          dy_q  <= {end_y_i[14], end_y_i} - {start_y_i[14], start_y_i};
          cx_q  <= {sumx_adj[15], sumx_adj[15:1]};
          cy_q  <= {sumy_adj[15], sumy_adj[15:1]};
        end
      end
      F_MUL: begin
        if (!ph_q) begin
          prod_q <= prod_d;
        end else begin
          case (op_q)
            OpDxDx:  s_q <= prod_q[31:0];
            OpDyDy:  s_q <= s_q + prod_q[31:0];
            OpDyOff: nx_q <= prod_q[29:0];
            OpDxOff: ny_q <= prod_q[29:0];
            OpNxNx:  sqx_q <= prod_q[57:0];
            OpNyNy: begin
              sqy_q  <= prod_q[57:0];
              rad_q  <= {28'd0, s_q};
              root_q <= '0;
              irem_q <= '0;
            end
            default: s_q <= s_q;
          endcase
        end
      end
      F_ROOT: begin
        rad_q  <= {rad_q[57:0], 2'b00};
        root_q <= {root_q[28:0], ige};
        irem_q <= irem_sub[30:0];
      end
      F_STEPS: begin
        steps_q <= steps_d;
        dquo_q  <= sqx_q;
        drem_q  <= '0;
      end
      F_DIV: begin
        dquo_q <= {dquo_q[56:0], dge};
        drem_q <= drem_sub[31:0];
        if (cnt_q == DivLast) begin
          rad_q  <= {2'b00, dquo_q[56:0], dge};
          root_q <= '0;
          irem_q <= '0;
        end
      end
      F_FIX: begin
        if (!pass_q) begin
          cx_q   <= fix_sum[15:0];
          dquo_q <= sqy_q;
          drem_q <= '0;
        end else begin
          cy_q <= fix_sum[15:0];
        end
      end
      default: begin
        s_q <= s_q;
      end
    endcase
  end

  assign in_ready_o  = (state_q == F_IDLE);
  assign job_valid_o = (state_q == F_PUSH);

  always_comb begin
    job_o       = '0;
    job_o.sx    = sx_q;
    job_o.sy    = sy_q;
    job_o.ex    = ex_q;
    job_o.ey    = ey_q;
    job_o.cx    = cx_q;
    job_o.cy    = cy_q;
    job_o.steps = steps_q;
  end

endmodule

### design/ebps_queue.sv
// Short job queue between the front and back ends of the path sampler.
// Depends on ebps_pkg for the job type.
module ebps_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           push_ready_o,
  input  ebps_pkg::job_t entry_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output ebps_pkg::job_t entry_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  ebps_pkg::job_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign entry_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH)) else $error("queue count beyond depth");
`endif

endmodule

### design/ebps_back.sv
// Back end: steps one path job through its eased samples and blends each point.
// Uses one shared 32x32 multiplier and a bit-serial divider; depends on ebps_pkg.
module ebps_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  ebps_pkg::job_t     job_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] point_x_o,
  output logic signed [15:0] point_y_o,
  output logic [5:0]         sample_index_o,
  output logic               last_point_o
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_DIV  = 4'b0010,
    B_MUL  = 4'b0100,
    B_OUT  = 4'b1000
  } bstate_e;

  localparam logic [3:0] OpWW  = 4'd0;
  localparam logic [3:0] OpW2W = 4'd1;
  localparam logic [3:0] OpOmOm = 4'd2;
  localparam logic [3:0] OpOmE = 4'd3;
  localparam logic [3:0] OpEE  = 4'd4;
  localparam logic [3:0] OpAx  = 4'd5;
  localparam logic [3:0] OpBx  = 4'd6;
  localparam logic [3:0] OpCx  = 4'd7;
  localparam logic [3:0] OpAy  = 4'd8;
  localparam logic [3:0] OpBy  = 4'd9;
  localparam logic [3:0] OpCy  = 4'd10;
  localparam logic [4:0] DivLast = 5'd30;

  bstate_e state_q, state_d;
  logic [3:0] op_q, op_d;
  logic       ph_q, ph_d;
  logic [4:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;

  ebps_pkg::job_t job_q;
  logic [30:0] quo_q;
  logic [5:0]  drem_q;
  logic [5:0]  i_q;
  logic [30:0] tq_q;
  logic [5:0]  tr_q;
  logic [30:0] w2_q, om_q, e_q, a_q, b_q, c_q;
  logic signed [63:0] prod_q;
  logic [47:0] acc_q;
  logic [15:0] xres_q, yres_q;
  logic [15:0] out_x_q, out_y_q;
  logic [5:0]  out_idx_q;
  logic        out_last_q;

  logic [30:0] w;
  logic signed [31:0] opa, opb;
  logic signed [63:0] prod_d;
  logic [6:0]  drem_sh, drem_sub;
  logic        dge;
  logic        out_free, last;
  logic [6:0]  tr_sum;
  logic        tr_wrap;
  logic [47:0] acc_sum;
  logic [15:0] sx16, sy16, ex16, ey16;

  function automatic logic [15:0] q30_trunc(logic [47:0] v);
    logic [47:0] t;
    t = v + (v[47] ? 48'd1073741823 : 48'd0);
    return t[45:30];
  endfunction

  assign sx16 = {job_q.sx[14], job_q.sx};
  assign sy16 = {job_q.sy[14], job_q.sy};
  assign ex16 = {job_q.ex[14], job_q.ex};
  assign ey16 = {job_q.ey[14], job_q.ey};
  assign w    = ebps_pkg::QOne - tq_q;

  always_comb begin
    opa = '0;
    opb = '0;
    case (op_q)
      OpWW: begin
        opa = {1'b0, w};
        opb = {1'b0, w};
      end
      OpW2W: begin
        opa = {1'b0, w2_q};
        opb = {1'b0, w};
      end
      OpOmOm: begin
        opa = {1'b0, om_q};
        opb = {1'b0, om_q};
      end
      OpOmE: begin
        opa = {1'b0, om_q};
        opb = {1'b0, e_q};
      end
      OpEE: begin
        opa = {1'b0, e_q};
        opb = {1'b0, e_q};
      end
      OpAx: begin
        opa = {1'b0, a_q};
        opb = {{16{sx16[15]}}, sx16};
      end
      OpBx: begin
        opa = {1'b0, b_q};
        opb = {{16{job_q.cx[15]}}, job_q.cx};
      end
      OpCx: begin
        opa = {1'b0, c_q};
        opb = {{16{ex16[15]}}, ex16};
      end
      OpAy: begin
        opa = {1'b0, a_q};
        opb = {{16{sy16[15]}}, sy16};
      end
      OpBy: begin
        opa = {1'b0, b_q};
        opb = {{16{job_q.cy[15]}}, job_q.cy};
      end
      OpCy: begin
        opa = {1'b0, c_q};
        opb = {{16{ey16[15]}}, ey16};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod_d = opa * opb;

  assign drem_sh  = {drem_q, quo_q[30]};
  assign dge      = drem_sh >= {1'b0, job_q.steps};
  assign drem_sub = dge ? (drem_sh - {1'b0, job_q.steps}) : drem_sh;

  assign out_free = !out_valid_q || out_ready_i;
  assign last     = (i_q == job_q.steps);
  assign tr_sum   = {1'b0, tr_q} + {1'b0, drem_q};
  assign tr_wrap  = tr_sum >= {1'b0, job_q.steps};
  assign acc_sum  = acc_q + prod_q[47:0];

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    ph_d        = ph_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      B_IDLE: begin
        if (job_valid_i) begin
          state_d = B_DIV;
          cnt_d   = '0;
        end
      end
      B_DIV: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == DivLast) begin
          state_d = B_MUL;
          op_d    = OpWW;
          ph_d    = 1'b0;
        end
      end
      B_MUL: begin
        ph_d = ~ph_q;
        if (ph_q) begin
          if (op_q == OpCy) begin
            state_d = B_OUT;
          end else begin
            op_d = op_q + 4'd1;
          end
        end
      end
      B_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (last) begin
            state_d = B_IDLE;
          end else begin
            state_d = B_MUL;
            op_d    = OpWW;
            ph_d    = 1'b0;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      op_q        <= '0;
      ph_q        <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      ph_q        <= ph_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (job_valid_i) begin
          job_q  <= job_i;
          quo_q  <= ebps_pkg::QOne;
          drem_q <= '0;
          i_q    <= '0;
          tq_q   <= '0;
          tr_q   <= '0;
        end
      end
      B_DIV: begin
        quo_q  <= {quo_q[29:0], dge};
        drem_q <= drem_sub[5:0];
      end
      B_MUL: begin
        if (!ph_q) begin
          prod_q <= prod_d;
        end else begin
          case (op_q)
            OpWW:   w2_q <= prod_q[60:30];
            OpW2W: begin
              om_q <= prod_q[60:30];
              e_q  <= ebps_pkg::QOne - prod_q[60:30];
            end
            OpOmOm: a_q <= prod_q[60:30];
            OpOmE:  b_q <= prod_q[59:29];
            OpEE:   c_q <= prod_q[60:30];
            OpAx:   acc_q <= prod_q[47:0];
            OpBx:   acc_q <= acc_sum;
            OpCx:   xres_q <= q30_trunc(acc_sum);
            OpAy:   acc_q <= prod_q[47:0];
            OpBy:   acc_q <= acc_sum;
            OpCy:   yres_q <= q30_trunc(acc_sum);
            default: acc_q <= acc_q;
          endcase
        end
      end
      B_OUT: begin
        if (out_free) begin
          out_x_q    <= xres_q;
          out_y_q    <= yres_q;
          out_idx_q  <= i_q;
          out_last_q <= last;
          if (!last) begin
            i_q <= i_q + 6'd1;
            if (tr_wrap) begin
              tr_q <= 6'(tr_sum - {1'b0, job_q.steps});
              tq_q <= tq_q + quo_q + 31'd1;
            end else begin
              tr_q <= tr_sum[5:0];
              tq_q <= tq_q + quo_q;
            end
          end
        end
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  assign job_ready_o    = (state_q == B_IDLE);
  assign out_valid_o    = out_valid_q;
  assign point_x_o      = out_x_q;
  assign point_y_o      = out_y_q;
  assign sample_index_o = out_idx_q;
  assign last_point_o   = out_last_q;

`ifndef NO_ASSERTIONS
  a_first_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_idx_q == '0) |-> out_x_q == sx16)
    else $error("first sample x differs from start point");
  a_first_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_idx_q == '0) |-> out_y_q == sy16)
    else $error("first sample y differs from start point");
`endif

endmodule

### design/eased_quadratic_bezier_path_sampler.sv
// The front end runs three bit-serial square roots and two bit-serial divisions per request
// (one root and no division for paths of length one or less); the back end then divides once for
// its step size and blends each sample with the shared multiplier. The path rate is set by that
// multiplier in the back end; the front takes the next request while the job queue has room.
// Reset: asynchronous, active low; clears all control state and drops pending output.
// Top level; instantiates ebps_front, ebps_queue and ebps_back; depends on ebps_pkg.
module eased_quadratic_bezier_path_sampler #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [14:0] start_x_i,
  input  logic signed [14:0] start_y_i,
  input  logic signed [14:0] end_x_i,
  input  logic signed [14:0] end_y_i,
  input  logic signed [14:0] offset_mag_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] point_x_o,
  output logic signed [15:0] point_y_o,
  output logic [5:0]         sample_index_o,
  output logic               last_point_o
);

  logic           f_valid, f_ready, b_valid, b_ready;
  ebps_pkg::job_t f_job, b_job;

  ebps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .offset_mag_i (offset_mag_i),
    .job_valid_o  (f_valid),
    .job_ready_i  (f_ready),
    .job_o        (f_job)
  );

  ebps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (f_valid),
    .push_ready_o (f_ready),
    .entry_i      (f_job),
    .pop_valid_o  (b_valid),
    .pop_i        (b_ready),
    .entry_o      (b_job)
  );

  ebps_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (b_valid),
    .job_ready_o    (b_ready),
    .job_i          (b_job),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .sample_index_o (sample_index_o),
    .last_point_o   (last_point_o)
  );

`ifndef NO_ASSERTIONS
  a_last_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_point_o |->
      (sample_index_o >= 6'(ebps_pkg::MinSteps)) &&
      (sample_index_o <= 6'(ebps_pkg::MaxSteps)))
    else $error("final sample index outside step range");
`endif

endmodule
